/* src/fcv_pkg.sv */
package fcv_pkg;

   localparam int unsigned MAX_BYTES = 2048;

   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned STATUS_W = 3;
   localparam int unsigned COUNT_W  = 11;
   localparam int unsigned VALUE_W  = 9;
   localparam int unsigned CSR_AW   = 3;
   localparam int unsigned CSR_DW   = 32;
   localparam int unsigned RSP_DW   = 32;

   // register index 0 at byte address 0, decoded on the word address bit
   localparam logic REG_MAX_LENGTH = 1'b0;

   localparam logic [COUNT_W-1:0] MAX_LENGTH_RESET = 11'd2047;

   // largest count representable by the length field, or MAX_BYTES - 1 if smaller
   localparam int unsigned CAP_INT =
      ((MAX_BYTES - 1) > ((1 << COUNT_W) - 1)) ? ((1 << COUNT_W) - 1) : (MAX_BYTES - 1);
   localparam logic [COUNT_W-1:0] LENGTH_CAP = COUNT_W'(CAP_INT);

   localparam logic [BYTE_W-1:0] SOH_CHAR   = 8'h01;
   localparam logic [BYTE_W-1:0] CHAR_ONE   = 8'h31;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;
   localparam logic [BYTE_W-1:0] CHAR_EQUAL = 8'h3d;
   // '1' + '0', already in the running sum when '=' arrives
   localparam logic [BYTE_W-1:0] TAG_PREFIX_SUM = 8'h61;

   localparam logic [VALUE_W-1:0] VALUE_SAT = 9'd256;
   localparam logic [BYTE_W-1:0]  RSUM_SAT  = 8'd255;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 3'd0,
      ST_MISMATCH  = 3'd1,
      ST_NO_DIGITS = 3'd2,
      ST_RANGE     = 3'd3,
      ST_NO_TAG    = 3'd4
   } status_type;

   typedef enum logic {
      PH_SEARCH = 1'b0,
      PH_VALUE  = 1'b1
   } phase_type;

   typedef enum logic [1:0] {
      MP_NONE = 2'd0,
      MP_ONE  = 2'd1,
      MP_ZERO = 2'd2
   } match_type;

   typedef struct packed {
      logic [COUNT_W-1:0] message_bytes;
      logic [BYTE_W-1:0]  received_sum;
      logic [BYTE_W-1:0]  computed_sum;
      status_type         status;
   } result_type;

endpackage

/* src/fcv_csr.sv */
module fcv_csr
   import fcv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready,
   output logic [COUNT_W-1:0] max_length
);

   logic [COUNT_W-1:0] max_length_ff;
   logic [COUNT_W-1:0] max_length_in;
   logic               wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      max_length_in = max_length_ff;
      if (wr_en && (csr_paddr[2] == REG_MAX_LENGTH)) begin
         max_length_in = csr_pwdata[COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= MAX_LENGTH_RESET;
      end else begin
         max_length_ff <= max_length_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_MAX_LENGTH) begin
         csr_prdata = {{(CSR_DW-COUNT_W){1'b0}}, max_length_ff};
      end
   end

   assign max_length = max_length_ff;

endmodule

/* src/fcv_parser.sv */
module fcv_parser
   import fcv_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [BYTE_W-1:0]  data_byte,
   input  logic               stream_end,
   input  logic [COUNT_W-1:0] max_length,
   output logic               emit,
   output result_type         result
);

   phase_type          phase_ff, phase_in;
   match_type          match_ff, match_in;
   logic [BYTE_W-1:0]  running_sum_ff, running_sum_in;
   logic [BYTE_W-1:0]  prefix_sum_ff, prefix_sum_in;
   logic [VALUE_W-1:0] value_acc_ff, value_acc_in;
   logic               digit_seen_ff, digit_seen_in;
   logic               digits_closed_ff, digits_closed_in;
   logic [COUNT_W-1:0] byte_count_ff, byte_count_in;

   logic               tag_done;
   logic               is_digit;
   logic [COUNT_W-1:0] count_next;
   logic [COUNT_W-1:0] limit;
   logic [11:0]        value_mac;

   assign tag_done   = (phase_ff == PH_SEARCH) && (match_ff == MP_ZERO)
                       && (data_byte == CHAR_EQUAL);
   assign is_digit   = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
   assign count_next = byte_count_ff + 1'b1;
   // acc * 10 + digit; acc stays at or below 256
   assign value_mac  = {value_acc_ff, 3'b000} + {2'b00, value_acc_ff, 1'b0}
                       + {8'd0, data_byte[3:0]};

   always_comb begin
      limit = (max_length > LENGTH_CAP) ? LENGTH_CAP : max_length;
      if (limit == '0) begin
         limit = COUNT_W'(1);
      end
   end

   // phase transition
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_SEARCH: if (tag_done) phase_in = PH_VALUE;
         PH_VALUE:  phase_in = PH_VALUE;
         default:   phase_in = PH_SEARCH;
      endcase
   end

   // per-byte datapath, before the end-of-message check
   always_comb begin
      match_in         = match_ff;
      running_sum_in   = running_sum_ff;
      prefix_sum_in    = prefix_sum_ff;
      value_acc_in     = value_acc_ff;
      digit_seen_in    = digit_seen_ff;
      digits_closed_in = digits_closed_ff;
      if (phase_ff == PH_SEARCH) begin
         running_sum_in = running_sum_ff + data_byte;
         if (tag_done) begin
            prefix_sum_in = running_sum_ff - TAG_PREFIX_SUM;
            match_in      = MP_NONE;
         end else if (data_byte == CHAR_ONE) begin
            match_in = MP_ONE;
         end else if ((match_ff == MP_ONE) && (data_byte == CHAR_ZERO)) begin
            match_in = MP_ZERO;
         end else begin
            match_in = MP_NONE;
         end
      end else if (!digits_closed_ff) begin
         if (is_digit) begin
            value_acc_in  = (value_mac > 12'(VALUE_SAT)) ? VALUE_SAT : value_mac[VALUE_W-1:0];
            digit_seen_in = 1'b1;
         end else begin
            digits_closed_in = 1'b1;
         end
      end
   end

   assign emit = ((phase_ff == PH_VALUE) && (data_byte == SOH_CHAR))
                 || stream_end || (count_next >= limit);

   // result, taken from the state after this byte
   always_comb begin
      result.message_bytes = count_next;
      result.computed_sum  = prefix_sum_in;
      result.received_sum  = value_acc_in[BYTE_W-1:0];
      result.status        = ST_OK;
      if (phase_in == PH_SEARCH) begin
         result.status       = ST_NO_TAG;
         result.computed_sum = '0;
         result.received_sum = '0;
      end else if (!digit_seen_in) begin
         result.status       = ST_NO_DIGITS;
         result.received_sum = '0;
      end else if (value_acc_in > VALUE_W'(RSUM_SAT)) begin
         result.status       = ST_RANGE;
         result.received_sum = RSUM_SAT;
      end else if (prefix_sum_in != value_acc_in[BYTE_W-1:0]) begin
         result.status = ST_MISMATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || (fire && emit)) begin
         phase_ff         <= PH_SEARCH;
         match_ff         <= MP_NONE;
         running_sum_ff   <= '0;
         prefix_sum_ff    <= '0;
         value_acc_ff     <= '0;
         digit_seen_ff    <= 1'b0;
         digits_closed_ff <= 1'b0;
         byte_count_ff    <= '0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         match_ff         <= match_in;
         running_sum_ff   <= running_sum_in;
         prefix_sum_ff    <= prefix_sum_in;
         value_acc_ff     <= value_acc_in;
         digit_seen_ff    <= digit_seen_in;
         digits_closed_ff <= digits_closed_in;
         byte_count_ff    <= count_next;
      end
   end

endmodule

/* src/fix_checksum_verifier_unit.sv */
// Channel   Direction  Handshake                  Payload
// req_      in         req_tvalid / req_tready    tdata: data_byte; tlast: stream_end
// rsp_      out        rsp_tvalid / rsp_tready    tdata: status, computed_sum,
//                                                 received_sum, message_bytes
// csr_      in         psel / penable / pready    max_length at address 0
//
// One byte per cycle sustained unless rsp_ stalls. A byte is registered on
// acceptance, parsed from the input register, and its result (if any) is
// registered and shown on rsp_. Parser state updates only when the result register
// can take a result, so a stalled rsp_tready holds back req_tready through the input
// register. Synchronous reset clears all control state and sets max_length to 2047.
module fix_checksum_verifier_unit
   import fcv_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] data_byte
   input  logic              req_tlast,   // stream_end
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [RSP_DW-1:0] rsp_tdata,   // [2:0] status, [10:3] computed_sum,
                                          // [18:11] received_sum, [29:19] message_bytes
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   output logic [CSR_DW-1:0] csr_prdata,
   output logic              csr_pready
);

   logic               in_valid_ff, in_valid_in;
   logic [BYTE_W-1:0]  in_byte_ff;
   logic               in_end_ff;
   logic               out_valid_ff, out_valid_in;
   result_type         out_data_ff;

   logic               fire;
   logic               emit;
   result_type         result;
   logic [COUNT_W-1:0] max_length;

   fcv_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .max_length  (max_length)
   );

   fcv_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .data_byte  (in_byte_ff),
      .stream_end (in_end_ff),
      .max_length (max_length),
      .emit       (emit),
      .result     (result)
   );

   assign fire       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (fire && emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tlast;
      end
      if (fire && emit) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DW-$bits(result_type)){1'b0}}, out_data_ff};

endmodule

/* src/fcv_monitor.sv */
module fcv_monitor
   import fcv_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_tvalid,
   input logic              rsp_tready,
   input logic [RSP_DW-1:0] rsp_tdata,
   input logic              csr_pready
);

   property p_rsp_hold;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata);
   endproperty
   a_rsp_hold: assert property (p_rsp_hold) else $error("result changed while stalled");

   property p_status_code;
      @(posedge clock) disable iff (reset)
         rsp_tvalid |-> (rsp_tdata[2:0] == ST_OK) || (rsp_tdata[2:0] == ST_MISMATCH)
                        || (rsp_tdata[2:0] == ST_NO_DIGITS) || (rsp_tdata[2:0] == ST_RANGE)
                        || (rsp_tdata[2:0] == ST_NO_TAG);
   endproperty
   a_status_code: assert property (p_status_code) else $error("bad status code");

   property p_no_tag_zero;
      @(posedge clock) disable iff (reset)
         rsp_tvalid && (rsp_tdata[2:0] == ST_NO_TAG) |-> (rsp_tdata[18:3] == '0);
   endproperty
   a_no_tag_zero: assert property (p_no_tag_zero) else $error("sums set without a tag");

   property p_count_nonzero;
      @(posedge clock) disable iff (reset)
         rsp_tvalid |-> (rsp_tdata[29:19] != '0) && (rsp_tdata[31:30] == '0);
   endproperty
   a_count_nonzero: assert property (p_count_nonzero) else $error("empty message reported");

   property p_csr_ready;
      @(posedge clock) disable iff (reset) csr_pready;
   endproperty
   a_csr_ready: assert property (p_csr_ready) else $error("csr_pready low");

endmodule

bind fix_checksum_verifier_unit fcv_monitor u_monitor (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);
